>>> rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the sprite frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // Upper bound on the number of frames in a sequence
  localparam int FRAME_LIMIT = 64;

  localparam int TIMER_W = 24;
  localparam int FRAME_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // Reset values of the configuration registers
  localparam logic [FRAME_W-1:0] FRAME_COUNT_RST    = 7'd1;
  localparam logic [2:0]         ANIM_MODE_RST      = 3'd0;
  localparam logic [TIMER_W-1:0] FRAME_DURATION_RST = 24'd25600;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_START      = 3'd1,
    ACT_STOP       = 3'd2,
    ACT_SET_FRAME  = 3'd3,
    ACT_SET_ACTIVE = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    MODE_LOOP      = 3'd0,
    MODE_ONCE_GONE = 3'd1,
    MODE_ONCE_STAY = 3'd2,
    MODE_ONCE_BACK = 3'd3,
    MODE_PING_PONG = 3'd4
  } anim_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT    = 2'd0,
    REG_ANIM_MODE      = 2'd1,
    REG_FRAME_DURATION = 2'd2
  } cfg_reg_t;

  // Sequencer state carried from one transaction to the next
  typedef struct packed {
    logic [TIMER_W-1:0] timer;
    logic [FRAME_W-1:0] frame;
    logic               backward;
    logic               running;
    logic               visible;
  } seq_state_t;

  // Configuration as seen by the step logic
  typedef struct packed {
    logic [FRAME_W-1:0] frame_count;
    logic [2:0]         anim_mode;
    logic [TIMER_W-1:0] frame_duration;
  } seq_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/sfs_if.sv
// ----------------------------------------------------------------------------
// sfs_in_if / sfs_out_if
// Valid/ready channels for sequencer commands and status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [15:0] elapsed;
  logic [5:0] frame_req;
  logic       active_req;

  modport source (output valid, action, elapsed, frame_req, active_req, input ready);
  modport sink   (input valid, action, elapsed, frame_req, active_req, output ready);
endinterface

interface sfs_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] frame_index;
  logic       is_animating;
  logic       is_active;
  logic       frame_changed;

  modport source (output valid, frame_index, is_animating, is_active, frame_changed,
                  input ready);
  modport sink   (input valid, frame_index, is_animating, is_active, frame_changed,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/sfs_step.sv
// ----------------------------------------------------------------------------
// sfs_step
// Next-state logic for one command: timer, frame stepping, end-of-sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_step
  import sfs_pkg::*;
(
  input  seq_state_t  cur,
  input  seq_cfg_t    cfg,
  input  logic [2:0]  action,
  input  logic [15:0] elapsed,
  input  logic [5:0]  frame_req,
  input  logic        active_req,
  output seq_state_t  nxt
);

  logic [FRAME_W-1:0] eff_count;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sat;
  logic               at_zero_back;
  logic [FRAME_W:0]   step_raw;
  logic               past_end;
  seq_state_t         stepped;

  // Frame counts above the limit behave as the limit
  assign eff_count = (int'(cfg.frame_count) > FRAME_LIMIT) ?
                     FRAME_W'(FRAME_LIMIT) : cfg.frame_count;

  assign sum = {1'b0, cur.timer} + (TIMER_W+1)'(elapsed);
  assign sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];

  assign at_zero_back = cur.backward && (cur.frame == '0);
  assign step_raw = cur.backward ? ({1'b0, cur.frame} - 1'b1)
                                 : ({1'b0, cur.frame} + 1'b1);
  assign past_end = !at_zero_back && (step_raw >= {1'b0, eff_count});

  // One frame step after the timer expires
  always_comb begin
    stepped       = cur;
    stepped.timer = '0;
    if (past_end) begin
      case (cfg.anim_mode)
        MODE_LOOP: begin
          stepped.frame = '0;
        end
        MODE_ONCE_GONE: begin
          stepped.frame   = eff_count;
          stepped.running = 1'b0;
          stepped.visible = 1'b0;
        end
        MODE_ONCE_STAY: begin
          stepped.frame   = (eff_count == '0) ? '0 : eff_count - 1'b1;
          stepped.running = 1'b0;
        end
        MODE_ONCE_BACK: begin
          stepped.frame   = '0;
          stepped.running = 1'b0;
        end
        default: begin
          // ping-pong: reversing undoes the step, frame stays put
          stepped.backward = !cur.backward;
        end
      endcase
    end else if (at_zero_back) begin
      stepped.frame = '0;
      if (cfg.anim_mode >= MODE_PING_PONG) begin
        stepped.backward = 1'b0;
      end
    end else begin
      stepped.frame = step_raw[FRAME_W-1:0];
    end
  end

  always_comb begin
    nxt = cur;
    unique case (action)
      ACT_TICK: begin
        if (cur.running) begin
          if (sat > cfg.frame_duration) begin
            nxt = stepped;
          end else begin
            nxt.timer = sat;
          end
        end
      end
      ACT_START: begin
        nxt.visible = 1'b1;
        nxt.running = 1'b1;
        nxt.frame   = '0;
      end
      ACT_STOP: begin
        nxt.running = 1'b0;
      end
      ACT_SET_FRAME: begin
        if ({1'b0, frame_req} < eff_count) begin
          nxt.frame = FRAME_W'(frame_req);
        end
      end
      ACT_SET_ACTIVE: begin
        nxt.visible = active_req && (eff_count != '0);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite animation frame sequencer with a valid/ready command channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one command per transaction: tick (elapsed time, 8 fraction
//          bits), start, stop, set frame or set active.
//   out_if returns exactly one status transaction per command: frame index,
//          animating and visible flags, and whether the frame changed.
//   cfg_*  writes frame_count (0), anim_mode (1) and frame_duration (2);
//          write only while no command is in flight.
// A command accepted at a clock edge shows its status from that edge onward in
// the output register. Throughput is one command per cycle while the receiver
// does not stall; the whole update (saturating timer add, duration compare,
// frame step) sits between the channel and the state/result registers.
// When the receiver stalls, the status holds in the output register and
// in_if.ready drops until it is taken; with the output empty or being drained,
// the next command is accepted in the same cycle.
// Reset (synchronous, active low) clears the state to frame 0, stopped,
// hidden, forward, timer zero; config returns to 1 frame, loop, 100.0 time.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sfs_in_if.sink                     in_if,
  sfs_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  seq_cfg_t   cfg_r;
  seq_state_t state_r;
  seq_state_t state_nxt;

  logic             out_valid_r;
  logic [FRAME_W-1:0] frame_index_r;
  logic             is_animating_r;
  logic             is_active_r;
  logic             frame_changed_r;
  logic             in_fire;

  // Accept, outside reset, whenever the result register is empty or being drained
  assign in_if.ready = rst_n && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count    <= FRAME_COUNT_RST;
      cfg_r.anim_mode      <= ANIM_MODE_RST;
      cfg_r.frame_duration <= FRAME_DURATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_COUNT:    cfg_r.frame_count    <= cfg_wdata[FRAME_W-1:0];
        REG_ANIM_MODE:      cfg_r.anim_mode      <= cfg_wdata[2:0];
        REG_FRAME_DURATION: cfg_r.frame_duration <= cfg_wdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  sfs_step u_step (
    .cur        (state_r),
    .cfg        (cfg_r),
    .action     (in_if.action),
    .elapsed    (in_if.elapsed),
    .frame_req  (in_if.frame_req),
    .active_req (in_if.active_req),
    .nxt        (state_nxt)
  );

  // State advances only on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: status after the command is applied
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_index_r   <= state_nxt.frame;
      is_animating_r  <= state_nxt.running;
      is_active_r     <= state_nxt.visible;
      frame_changed_r <= (state_nxt.frame != state_r.frame);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.frame_index   = frame_index_r;
  assign out_if.is_animating  = is_animating_r;
  assign out_if.is_active     = is_active_r;
  assign out_if.frame_changed = frame_changed_r;

endmodule

`default_nettype wire

>>> rtl/core/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks for the sprite frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_checker
  import sfs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [FRAME_W-1:0] frame_index
);

  // A stalled status transaction is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("status dropped while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("status valid after reset");

  // Every accepted command produces a status in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted command produced no status");

  // An empty result register never blocks the command channel
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("command stalled with empty output");

  // The frame never passes the frame limit
  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(frame_index) <= FRAME_LIMIT))
    else $error("frame index out of range");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .frame_index (out_if.frame_index)
);

`default_nettype wire
